/* rtl/core/macd_indicator_defines.svh */
// Assertion macros shared by the MACD indicator checker.
// No dependencies.
`ifndef MACD_INDICATOR_DEFINES_SVH
`define MACD_INDICATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MACD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("macd check failed");
// Next-cycle implication checked outside reset.
`define MACD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("macd check failed");
`endif

/* rtl/core/macd_pkg.sv */
// Package for the MACD indicator: sequencer state type and fixed constants.
// No dependencies.
package macd_pkg;
  // Price format: unsigned fixed point. The fraction bits do not change the
  // arithmetic, since every average stays in the price's own format.
  localparam int PriceWidth = 32;
  localparam int FractionBits = 16;
  localparam int CountWidth = 9;
  localparam int SatCount = 256;
  localparam int OutMacdWidth = 33;
  localparam int OutHistWidth = 34;
  localparam logic [1:0] RegShort = 2'd0;
  localparam logic [1:0] RegLong = 2'd1;
  localparam logic [1:0] RegSignal = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHORT,
    ST_LONG,
    ST_SIGNAL,
    ST_DIV,
    ST_OUT
  } state_t;

  // Which average the shared unit currently works on.
  typedef enum logic [1:0] {
    SEL_SHORT,
    SEL_LONG,
    SEL_SIGNAL
  } sel_t;
endpackage

/* rtl/core/macd_indicator.sv */
// Top level of the MACD indicator: handshake, config registers, sequencer and a
// shared bit-serial divider. Depends on macd_pkg.
//
// One price beat enters, and the block updates the short, long and signal
// averages in turn with a single restoring divider that produces one quotient
// bit per cycle. Each average needs at most one division (the seed mean by n,
// or the move (x-avg)*2 by n+1) over DW bits, where DW is the working width
// (price width plus 11, so 43 for the 32-bit price). The sequencer spends a
// set-up step on each average and a divider step when that average divides,
// then goes to its output step and back to idle. An average that is still
// collecting its seed sum skips the divider. The block takes one beat at a
// time: in_stall is high from the accepting edge until the sequencer is idle
// again. The result sits in its own output register, so a waiting result
// does not block the next price; only when a new result is ready while the
// old beat is still stalled does the sequencer hold in its output step until
// the old beat is taken, and the input stays stalled meanwhile. A result
// beat is given only once the long period is complete. Periods of zero act
// as one.
module macd_indicator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] close_price,
  input  logic        start_series,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [32:0] macd_value,
  output logic signed [32:0] signal_value,
  output logic signed [33:0] histogram_value,
  output logic        signal_valid
);
  // Working width: price plus sign and sum growth over 256 samples and signal headroom.
  localparam int DW = macd_pkg::PriceWidth + 11;
  localparam int CW = $clog2(DW + 1);

  logic [7:0] short_period, long_period, signal_period;
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_period <= 8'd12;
      long_period <= 8'd26;
      signal_period <= 8'd9;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        macd_pkg::RegShort: short_period <= pwdata[7:0];
        macd_pkg::RegLong: long_period <= pwdata[7:0];
        macd_pkg::RegSignal: signal_period <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      macd_pkg::RegShort: prdata = {24'd0, short_period};
      macd_pkg::RegLong: prdata = {24'd0, long_period};
      macd_pkg::RegSignal: prdata = {24'd0, signal_period};
      default: prdata = 32'd0;
    endcase
  end

  function automatic logic [8:0] eff(input logic [7:0] p);
    eff = (p == 8'd0) ? 9'd1 : {1'b0, p};
  endfunction

  // Series state.
  logic signed [DW-1:0] avg_s, avg_l, avg_g, sum_s, sum_l, sum_g;
  logic [macd_pkg::CountWidth-1:0] sample_count, difference_count;
  logic signed [DW-1:0] x;
  logic signed [DW-1:0] macd_r;
  macd_pkg::state_t state, state_next, after_st;
  macd_pkg::sel_t sel;
  logic emit;

  // Divider registers: sign-magnitude restoring division, one bit per cycle.
  logic [DW-1:0] dq;      // dividend shifting out, quotient shifting in
  logic [9:0] drem;
  logic [8:0] dden;
  logic dneg;
  logic [CW-1:0] dcnt;

  logic take;
  assign take = in_valid && !in_stall;
  assign in_stall = (state != macd_pkg::ST_IDLE);

  logic [8:0] n_s, n_l, n_g, n_cur;
  assign n_s = eff(short_period);
  assign n_l = eff(long_period);
  assign n_g = eff(signal_period);

  // Per-average work selection.
  logic signed [DW-1:0] a_cur, s_cur, x_cur;
  logic [macd_pkg::CountWidth-1:0] c_cur;
  always_comb begin
    case (sel)
      macd_pkg::SEL_SHORT: begin
        a_cur = avg_s; s_cur = sum_s; x_cur = x; c_cur = sample_count; n_cur = n_s;
      end
      macd_pkg::SEL_LONG: begin
        a_cur = avg_l; s_cur = sum_l; x_cur = x; c_cur = sample_count; n_cur = n_l;
      end
      default: begin
        a_cur = avg_g; s_cur = sum_g; x_cur = macd_r; c_cur = difference_count;
        n_cur = n_g;
      end
    endcase
  end

  logic signed [DW-1:0] new_sum, move_num, num;
  logic seeding, seed_now;
  assign new_sum = s_cur + x_cur;
  assign move_num = (x_cur - a_cur) <<< 1;
  assign seeding = {1'b0, c_cur} < {1'b0, n_cur};
  assign seed_now = c_cur == n_cur;
  assign num = seed_now ? new_sum : move_num;

  logic [DW-1:0] num_mag;
  assign num_mag = num[DW-1] ? DW'(-num) : DW'(num);

  logic [9:0] trial;
  logic [10:0] trial_sub;
  assign trial = {drem[8:0], dq[DW-1]};
  assign trial_sub = {1'b0, trial} - {2'b00, dden};

  // The last quotient bit lands together with write-back, so form it here.
  logic [DW-1:0] q_final;
  logic signed [DW-1:0] quot_final, div_result;
  assign q_final = {dq[DW-2:0], ~trial_sub[10]};
  assign quot_final = dneg ? -$signed(q_final) : $signed(q_final);
  assign div_result = seed_now ? quot_final : a_cur + quot_final;

  // Both counters stop at 256, which is the only value with the top bit set.
  logic [macd_pkg::CountWidth-1:0] cnt_inc_s, cnt_inc_d;
  assign cnt_inc_s = sample_count[macd_pkg::CountWidth-1] ?
                     sample_count : sample_count + 1'b1;
  assign cnt_inc_d = difference_count[macd_pkg::CountWidth-1] ?
                     difference_count : difference_count + 1'b1;

  logic go_signal;
  assign go_signal = {1'b0, sample_count} >= {1'b0, n_l};

  // Where the sequence goes once the current average is finished.
  always_comb begin
    case (sel)
      macd_pkg::SEL_SHORT: after_st = macd_pkg::ST_LONG;
      macd_pkg::SEL_LONG: after_st = go_signal ? macd_pkg::ST_SIGNAL : macd_pkg::ST_OUT;
      default: after_st = macd_pkg::ST_OUT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= macd_pkg::ST_IDLE;
    else state <= state_next;
  end

  logic do_div;
  logic out_busy;
  assign out_busy = out_valid && out_stall;
  always_comb begin
    state_next = state;
    do_div = 1'b0;
    case (state)
      macd_pkg::ST_IDLE: if (take) state_next = macd_pkg::ST_SHORT;
      macd_pkg::ST_SHORT, macd_pkg::ST_LONG, macd_pkg::ST_SIGNAL: begin
        if (!seeding) begin
          do_div = 1'b1;
          state_next = macd_pkg::ST_DIV;
        end else state_next = after_st;
      end
      macd_pkg::ST_DIV: if (dcnt == CW'(0)) state_next = after_st;
      // A new result waits here while the previous beat is still stalled.
      macd_pkg::ST_OUT: if (!emit || !out_busy) state_next = macd_pkg::ST_IDLE;
      default: state_next = macd_pkg::ST_IDLE;
    endcase
  end

  // An average is finished when its divider step ends, or at once when it
  // only adds to its seed sum.
  logic div_done, in_avg, step_done, load_out;
  logic signed [DW-1:0] long_now;
  assign div_done = (state == macd_pkg::ST_DIV) && (dcnt == CW'(0));
  assign in_avg = (state == macd_pkg::ST_SHORT) || (state == macd_pkg::ST_LONG) ||
                  (state == macd_pkg::ST_SIGNAL);
  assign step_done = (in_avg && !do_div) || div_done;
  assign long_now = div_done ? div_result : avg_l;
  assign load_out = (state == macd_pkg::ST_OUT) && emit && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_s <= '0; avg_l <= '0; avg_g <= '0;
      sum_s <= '0; sum_l <= '0; sum_g <= '0;
      sample_count <= '0; difference_count <= '0;
      out_valid <= 1'b0; emit <= 1'b0; sel <= macd_pkg::SEL_SHORT;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        macd_pkg::ST_IDLE: if (take) begin
          x <= DW'(close_price[macd_pkg::PriceWidth-1:0]);
          sel <= macd_pkg::SEL_SHORT;
          emit <= 1'b0;
          if (start_series) begin
            avg_s <= '0; avg_l <= '0; avg_g <= '0;
            sum_s <= '0; sum_l <= '0; sum_g <= '0;
            sample_count <= {{(macd_pkg::CountWidth-1){1'b0}}, 1'b1};
            difference_count <= '0;
          end else sample_count <= cnt_inc_s;
        end
        macd_pkg::ST_SHORT, macd_pkg::ST_LONG, macd_pkg::ST_SIGNAL: begin
          if (seeding || seed_now) begin
            case (sel)
              macd_pkg::SEL_SHORT: sum_s <= new_sum;
              macd_pkg::SEL_LONG: sum_l <= new_sum;
              default: sum_g <= new_sum;
            endcase
          end
          if (do_div) begin
            dq <= num_mag; dneg <= num[DW-1]; drem <= '0;
            dden <= seed_now ? n_cur : n_cur + 9'd1;
            dcnt <= CW'(DW - 1);
          end
        end
        macd_pkg::ST_DIV: begin
          drem <= trial_sub[10] ? trial : trial_sub[9:0];
          dq <= q_final;
          if (dcnt != CW'(0)) dcnt <= dcnt - 1'b1;
        end
        default: ;
      endcase
      if (div_done) begin
        case (sel)
          macd_pkg::SEL_SHORT: avg_s <= div_result;
          macd_pkg::SEL_LONG: avg_l <= div_result;
          default: avg_g <= div_result;
        endcase
      end
      if (step_done) begin
        case (sel)
          macd_pkg::SEL_SHORT: sel <= macd_pkg::SEL_LONG;
          macd_pkg::SEL_LONG: if (go_signal) begin
            macd_r <= avg_s - long_now; difference_count <= cnt_inc_d;
            sel <= macd_pkg::SEL_SIGNAL; emit <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Result registers.
  logic sv;
  assign sv = {1'b0, difference_count} >= {1'b0, n_g};
  always_ff @(posedge clk) begin
    if (load_out) begin
      macd_value <= macd_r[32:0];
      signal_valid <= sv;
      signal_value <= sv ? avg_g[32:0] : '0;
      histogram_value <= sv ? 34'(macd_r - avg_g) : '0;
    end
  end

  logic unused;
  assign unused = ^{pwdata[31:8], paddr[1:0]};
endmodule

/* rtl/core/macd_checker.sv */
// Port-level checker for the MACD indicator, bound to the top level.
// Depends on macd_indicator_defines.svh.
`include "macd_indicator_defines.svh"
module macd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signal_valid,
  input logic signed [32:0] macd_value,
  input logic signed [32:0] signal_value,
  input logic signed [33:0] histogram_value
);
  `MACD_ASSERT_IMP(a_sig_zero, out_valid && !signal_valid, signal_value == 0)
  `MACD_ASSERT_IMP(a_hist_zero, out_valid && !signal_valid, histogram_value == 0)
  `MACD_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)
  `MACD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(macd_value))
endmodule

bind macd_indicator macd_checker u_chk (.*);
